// File: sv/rdu_pkg.sv
// Shared widths, stage counts and types for the refraction direction unit.
`timescale 1ns / 1ps
`default_nettype none

package rdu_pkg;

	// Field widths
	localparam int COMP_W     = 16;                  // Q2.14 vector components
	localparam int IDX_W      = 15;                  // Q2.13 refractive indices
	localparam int RATIO_W    = 20;                  // Q4.16 index ratio
	localparam int RATIO_FRAC = 16;
	localparam int RATIO_HEAD = RATIO_W - RATIO_FRAC;

	// Ratio divider: restoring, four quotient bits per stage
	localparam int DIV_STG    = 5;
	localparam int DIV_STEPS  = RATIO_W / DIV_STG;

	// Intermediate widths
	localparam int DOT_W      = 34;                  // dot(N,I), Q.28
	localparam int C1_W       = 19;                  // c1, Q.14
	localparam int K_W        = 38;                  // 1 - c1^2, Q.28
	localparam int RSQ_W      = 2 * RATIO_W;         // ratio^2, Q.32
	localparam int NSQ_W      = RSQ_W - RATIO_FRAC;  // ratio^2, Q.16
	localparam int R_W        = 64;                  // radicand, Q.44
	localparam int NC1_W      = 40;                  // n*c1, Q.30
	localparam int NIV_W      = 37;                  // n*I, Q.30
	localparam int T_W        = 42;                  // n*c1 - c2, Q.30
	localparam int TNV_W      = 58;                  // t*N, Q.44
	localparam int V_W        = 59;                  // n*I + t*N, Q.44
	localparam int NIV_SH     = 14;                  // Q.30 -> Q.44
	localparam int C2_SH      = 8;                   // Q.22 -> Q.30
	localparam int OUT_SH     = 30;                  // Q.44 -> Q.14
	localparam int C1_SH      = 14;                  // Q.28 -> Q.14

	// Square root: two root bits per stage
	localparam int ROOT_W     = R_W / 2;
	localparam int SQ_STEPS   = 2;
	localparam int SQ_STG     = ROOT_W / SQ_STEPS;
	localparam int SQ_REM_W   = ROOT_W + 2;

	// Fixed-point ones
	localparam logic signed [K_W-1:0] ONE_Q28 = K_W'(64'sd1 <<< 28);
	localparam logic signed [R_W-1:0] ONE_Q44 = R_W'(64'sd1 <<< 44);

	typedef logic signed [COMP_W-1:0] comp_t;

	// Payload that rides alongside the square root stages
	typedef struct packed {
		logic                         tir;
		logic [NC1_W-1:0]             nc1;
		logic [2:0][NIV_W-1:0]        niv;
		logic [2:0][COMP_W-1:0]       nv;
	} side_t;

endpackage

`default_nettype wire

// File: sv/rdu_div.sv
// Pipelined restoring divider forming the saturated Q4.16 index ratio.
`timescale 1ns / 1ps
`default_nettype none

module rdu_div import rdu_pkg::*; (
	input  wire logic               clk,
	input  wire logic [DIV_STG-1:0] en,
	input  wire logic [IDX_W-1:0]   n1,
	input  wire logic [IDX_W-1:0]   n2,
	output logic [RATIO_W-1:0]      ratio
);

	logic [IDX_W-1:0]   rem_s   [DIV_STG];
	logic [RATIO_W-1:0] quo_s   [DIV_STG];
	logic [RATIO_W-1:0] dbits_s [DIV_STG];
	logic [IDX_W-1:0]   den_s   [DIV_STG];
	logic               ovf_s   [DIV_STG];

	for (genvar g = 0; g < DIV_STG; g++) begin : g_stage
		logic [IDX_W-1:0]   rem_in, den_in, rem_c;
		logic [RATIO_W-1:0] quo_in, db_in, quo_c, db_c;
		logic               ovf_in;
		logic [IDX_W:0]     trial;

		if (g == 0) begin : g_first
			// quotient of 2^20 or more saturates; also covers a zero divisor
			assign ovf_in = ({{RATIO_HEAD{1'b0}}, n1} >= {n2, {RATIO_HEAD{1'b0}}});
			assign rem_in = n1 >> RATIO_HEAD;
			assign db_in  = {n1[RATIO_HEAD-1:0], {RATIO_FRAC{1'b0}}};
			assign quo_in = '0;
			assign den_in = n2;
		end else begin : g_next
			assign ovf_in = ovf_s[g-1];
			assign rem_in = rem_s[g-1];
			assign db_in  = dbits_s[g-1];
			assign quo_in = quo_s[g-1];
			assign den_in = den_s[g-1];
		end

		// four quotient bits, one trial subtract each
		always_comb begin
			rem_c = rem_in;
			quo_c = quo_in;
			db_c  = db_in;
			trial = '0;
			for (int i = 0; i < DIV_STEPS; i++) begin
				trial = {rem_c, db_c[RATIO_W-1]};
				db_c  = db_c << 1;
				if (trial >= {1'b0, den_in}) begin
					rem_c = IDX_W'(trial - {1'b0, den_in});
					quo_c = {quo_c[RATIO_W-2:0], 1'b1};
				end else begin
					rem_c = trial[IDX_W-1:0];
					quo_c = {quo_c[RATIO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				rem_s[g]   <= rem_c;
				quo_s[g]   <= quo_c;
				dbits_s[g] <= db_c;
				den_s[g]   <= den_in;
				ovf_s[g]   <= ovf_in;
			end
		end
	end

	assign ratio = ovf_s[DIV_STG-1] ? '1 : quo_s[DIV_STG-1];

endmodule

`default_nettype wire

// File: sv/rdu_sqrt.sv
// Pipelined digit-by-digit integer square root with a payload that travels along.
`timescale 1ns / 1ps
`default_nettype none

module rdu_sqrt import rdu_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic [SQ_STG-1:0] en,
	input  wire logic [R_W-1:0]    rad_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic [ROOT_W-1:0]      root,
	output logic [SIDE_W-1:0]      side_out
);

	logic [SQ_REM_W-1:0] rem_s  [SQ_STG];
	logic [ROOT_W-1:0]   root_s [SQ_STG];
	logic [R_W-1:0]      rad_s  [SQ_STG];
	logic [SIDE_W-1:0]   side_s [SQ_STG];

	for (genvar g = 0; g < SQ_STG; g++) begin : g_stage
		logic [SQ_REM_W-1:0]   rem_in, rem_c;
		logic [ROOT_W-1:0]     root_in, root_c;
		logic [R_W-1:0]        rad_in_g, rad_c;
		logic [SIDE_W-1:0]     side_in_g;
		logic [SQ_REM_W+1:0]   cur, trial;

		if (g == 0) begin : g_first
			assign rem_in    = '0;
			assign root_in   = '0;
			assign rad_in_g  = rad_in;
			assign side_in_g = side_in;
		end else begin : g_next
			assign rem_in    = rem_s[g-1];
			assign root_in   = root_s[g-1];
			assign rad_in_g  = rad_s[g-1];
			assign side_in_g = side_s[g-1];
		end

		// bring down two radicand bits, try root*4+1
		always_comb begin
			rem_c  = rem_in;
			root_c = root_in;
			rad_c  = rad_in_g;
			cur    = '0;
			trial  = '0;
			for (int i = 0; i < SQ_STEPS; i++) begin
				cur   = {rem_c, rad_c[R_W-1 -: 2]};
				rad_c = rad_c << 2;
				trial = {2'b00, root_c, 2'b01};
				if (cur >= trial) begin
					rem_c  = SQ_REM_W'(cur - trial);
					root_c = {root_c[ROOT_W-2:0], 1'b1};
				end else begin
					rem_c  = cur[SQ_REM_W-1:0];
					root_c = {root_c[ROOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				rem_s[g]  <= rem_c;
				root_s[g] <= root_c;
				rad_s[g]  <= rad_c;
				side_s[g] <= side_in_g;
			end
		end
	end

	assign root     = root_s[SQ_STG-1];
	assign side_out = side_s[SQ_STG-1];

endmodule

`default_nettype wire

// File: sv/refract_direction_unit_core.sv
// Throughput: one request per cycle; the 20-bit ratio divider (4 bits a stage) and
//   the 32-bit square root (2 bits a stage) are fully pipelined; out_stall can stall them.
// Stalls: a stage loads if out_stall is low or it or a later one is empty; bubbles close up.
// Reset: arst_n clears all stage valid bits; the datapath registers are not reset.
// Total internal reflection returns a zero vector with total_reflection set.
`timescale 1ns / 1ps
`default_nettype none

module refract_direction_unit_core import rdu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic signed [15:0] normal_x,
	input  wire logic signed [15:0] normal_y,
	input  wire logic signed [15:0] normal_z,
	input  wire logic signed [15:0] dir_x,
	input  wire logic signed [15:0] dir_y,
	input  wire logic signed [15:0] dir_z,
	input  wire logic [14:0]       index_from,
	input  wire logic [14:0]       index_to,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [15:0]     out_x,
	output logic signed [15:0]     out_y,
	output logic signed [15:0]     out_z,
	output logic                   total_reflection
);

	localparam int NSTG     = 28;
	localparam int SQ_FIRST = 9;
	localparam int SQ_LAST  = SQ_FIRST + SQ_STG - 1;
	localparam int SIDE_W   = $bits(side_t);

	// stage valid bits and load enables
	logic [NSTG:1] vld_q;
	logic [NSTG:1] vld_in;
	logic [NSTG:1] en;

	for (genvar k = 1; k <= NSTG; k++) begin : g_en
		assign en[k] = ~out_stall | ~(&vld_q[NSTG:k]);
	end

	assign vld_in    = {vld_q[NSTG-1:1], in_valid};
	assign in_stall  = ~en[1];
	assign out_valid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (en[k]) vld_q[k] <= vld_in[k];
			end
		end
	end

	comp_t nv_in [3];
	comp_t iv_in [3];
	assign nv_in[0] = normal_x;
	assign nv_in[1] = normal_y;
	assign nv_in[2] = normal_z;
	assign iv_in[0] = dir_x;
	assign iv_in[1] = dir_y;
	assign iv_in[2] = dir_z;

	// ratio n1/n2, stages 1..5
	logic [RATIO_W-1:0] ratio;

	rdu_div u_div (
		.clk   (clk),
		.en    (en[DIV_STG:1]),
		.n1    (index_from),
		.n2    (index_to),
		.ratio (ratio)
	);

	// stage 1: dot product terms
	comp_t                    nv_s1 [3];
	comp_t                    iv_s1 [3];
	logic signed [2*COMP_W-1:0] pr_s1 [3];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int j = 0; j < 3; j++) begin
				nv_s1[j] <= nv_in[j];
				iv_s1[j] <= iv_in[j];
				pr_s1[j] <= nv_in[j] * iv_in[j];
			end
		end
	end

	// stage 2: dot product sum
	comp_t                  nv_s2 [3];
	comp_t                  iv_s2 [3];
	logic signed [DOT_W-1:0] d_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			nv_s2 <= nv_s1;
			iv_s2 <= iv_s1;
			d_s2  <= DOT_W'(pr_s1[0]) + DOT_W'(pr_s1[1]) + DOT_W'(pr_s1[2]);
		end
	end

	// stage 3: c1 = -d rounded half up to Q.14
	logic signed [DOT_W:0]  negd_c;
	comp_t                  nv_s3 [3];
	comp_t                  iv_s3 [3];
	logic signed [C1_W-1:0] c1_s3;

	assign negd_c = -(DOT_W + 1)'(d_s2) + (DOT_W + 1)'(1 << (C1_SH - 1));

	always_ff @(posedge clk) begin
		if (en[3]) begin
			nv_s3 <= nv_s2;
			iv_s3 <= iv_s2;
			c1_s3 <= negd_c[C1_SH +: C1_W];
		end
	end

	// stage 4: c1 squared
	comp_t                  nv_s4 [3];
	comp_t                  iv_s4 [3];
	logic signed [C1_W-1:0] c1_s4;
	logic signed [K_W-1:0]  c1sq_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			nv_s4   <= nv_s3;
			iv_s4   <= iv_s3;
			c1_s4   <= c1_s3;
			c1sq_s4 <= K_W'(c1_s3) * K_W'(c1_s3);
		end
	end

	// stage 5: k = 1 - c1^2 (ratio leaves the divider here)
	comp_t                  nv_s5 [3];
	comp_t                  iv_s5 [3];
	logic signed [C1_W-1:0] c1_s5;
	logic signed [K_W-1:0]  k_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			nv_s5 <= nv_s4;
			iv_s5 <= iv_s4;
			c1_s5 <= c1_s4;
			k_s5  <= ONE_Q28 - c1sq_s4;
		end
	end

	// stage 6: ratio products
	logic signed [RATIO_W:0]  ratio_sgn;
	comp_t                    nv_s6 [3];
	logic signed [NIV_W-1:0]  niv_s6 [3];
	logic signed [NC1_W-1:0]  nc1_s6;
	logic [RSQ_W-1:0]         rsq_s6;
	logic signed [K_W-1:0]    k_s6;

	assign ratio_sgn = $signed({1'b0, ratio});

	always_ff @(posedge clk) begin
		if (en[6]) begin
			nv_s6  <= nv_s5;
			k_s6   <= k_s5;
			rsq_s6 <= RSQ_W'(ratio) * RSQ_W'(ratio);
			nc1_s6 <= NC1_W'(ratio_sgn) * NC1_W'(c1_s5);
			for (int j = 0; j < 3; j++) begin
				niv_s6[j] <= NIV_W'(ratio_sgn) * NIV_W'(iv_s5[j]);
			end
		end
	end

	// stage 7: nsq * k
	logic signed [NSQ_W:0]   nsq_sgn;
	comp_t                   nv_s7 [3];
	logic signed [NIV_W-1:0] niv_s7 [3];
	logic signed [NC1_W-1:0] nc1_s7;
	logic signed [R_W-1:0]   prod_s7;

	assign nsq_sgn = $signed({1'b0, rsq_s6[RSQ_W-1:RATIO_FRAC]});

	always_ff @(posedge clk) begin
		if (en[7]) begin
			nv_s7   <= nv_s6;
			niv_s7  <= niv_s6;
			nc1_s7  <= nc1_s6;
			prod_s7 <= R_W'(nsq_sgn) * R_W'(k_s6);
		end
	end

	// stage 8: radicand and the reflection test
	logic signed [R_W-1:0] r_c;
	side_t                 side_c;
	side_t                 side_s8;
	logic [R_W-1:0]        rad_s8;

	assign r_c = ONE_Q44 - prod_s7;

	always_comb begin
		side_c.tir = r_c[R_W-1];
		side_c.nc1 = nc1_s7;
		for (int j = 0; j < 3; j++) begin
			side_c.niv[j] = niv_s7[j];
			side_c.nv[j]  = nv_s7[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			side_s8 <= side_c;
			rad_s8  <= r_c[R_W-1] ? '0 : r_c;
		end
	end

	// stages 9..24: square root
	logic [ROOT_W-1:0] root;
	logic [SIDE_W-1:0] side_sq;
	side_t             side_q;

	rdu_sqrt #(
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.en       (en[SQ_LAST:SQ_FIRST]),
		.rad_in   (rad_s8),
		.side_in  (side_s8),
		.root     (root),
		.side_out (side_sq)
	);

	assign side_q = side_t'(side_sq);

	// stage 25: t = n*c1 - c2
	logic signed [T_W-1:0]   c2_c;
	logic signed [T_W-1:0]   t_s25;
	comp_t                   nv_s25 [3];
	logic signed [NIV_W-1:0] niv_s25 [3];
	logic                    tir_s25;

	assign c2_c = $signed({2'b00, root, {C2_SH{1'b0}}});

	always_ff @(posedge clk) begin
		if (en[25]) begin
			t_s25   <= T_W'($signed(side_q.nc1)) - c2_c;
			tir_s25 <= side_q.tir;
			for (int j = 0; j < 3; j++) begin
				nv_s25[j]  <= $signed(side_q.nv[j]);
				niv_s25[j] <= $signed(side_q.niv[j]);
			end
		end
	end

	// stage 26: t * N
	logic signed [TNV_W-1:0] tnv_s26 [3];
	logic signed [NIV_W-1:0] niv_s26 [3];
	logic                    tir_s26;

	always_ff @(posedge clk) begin
		if (en[26]) begin
			niv_s26 <= niv_s25;
			tir_s26 <= tir_s25;
			for (int j = 0; j < 3; j++) begin
				tnv_s26[j] <= TNV_W'(t_s25) * TNV_W'(nv_s25[j]);
			end
		end
	end

	// stage 27: n*I + t*N in Q.44
	logic signed [V_W-1:0] v_s27 [3];
	logic                  tir_s27;

	always_ff @(posedge clk) begin
		if (en[27]) begin
			tir_s27 <= tir_s26;
			for (int j = 0; j < 3; j++) begin
				v_s27[j] <= (V_W'(niv_s26[j]) <<< NIV_SH) + V_W'(tnv_s26[j]);
			end
		end
	end

	// stage 28: round half up to Q.14 and saturate
	function automatic comp_t round_sat(input logic signed [V_W-1:0] v);
		logic signed [V_W:0]        vr;
		logic signed [V_W-OUT_SH:0] sh;
		begin
			vr = (V_W + 1)'(v) + (V_W + 1)'(64'sd1 <<< (OUT_SH - 1));
			sh = vr[V_W:OUT_SH];
			if (sh > (V_W - OUT_SH + 1)'(32767)) begin
				round_sat = comp_t'(16'sh7fff);
			end else if (sh < -(V_W - OUT_SH + 1)'(32768)) begin
				round_sat = comp_t'(16'sh8000);
			end else begin
				round_sat = sh[COMP_W-1:0];
			end
		end
	endfunction

	comp_t o_s28 [3];
	logic  tir_s28;

	always_ff @(posedge clk) begin
		if (en[28]) begin
			tir_s28 <= tir_s27;
			for (int j = 0; j < 3; j++) begin
				o_s28[j] <= tir_s27 ? '0 : round_sat(v_s27[j]);
			end
		end
	end

	assign out_x            = o_s28[0];
	assign out_y            = o_s28[1];
	assign out_z            = o_s28[2];
	assign total_reflection = tir_s28;

	// an empty output stage means nothing can hold back the input
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output stage is empty");

	// an accepted request always lands in stage 1
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[1])
		else $error("accepted request lost at stage 1");

	// reflection results carry a zero vector
	a_tir_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && total_reflection) |-> (out_x == '0 && out_y == '0 && out_z == '0))
		else $error("total reflection with nonzero vector");

	// a result held by the consumer stays valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

endmodule

`default_nettype wire

// File: test/refract_direction_unit_core_tb.sv
// Self-checking testbench for the refraction direction unit: directed table, then random rays.
`timescale 1ns / 1ps
`default_nettype none

module refract_direction_unit_core_tb import rdu_pkg::*; ;

	localparam int LATENCY   = 28;
	localparam int N_RANDOM  = 900;
	localparam int CYCLE_CAP = 200000;
	localparam logic signed [15:0] ONE  = 16'sd16384;
	localparam logic [14:0]        IDX1 = 15'd8192;

	typedef struct {
		logic signed [15:0] nx, ny, nz, ix, iy, iz;
		logic [14:0]        n1, n2;
	} ray_t;

	typedef struct {
		logic signed [15:0] x, y, z;
		logic               tir;
	} refr_t;

	typedef struct {
		ray_t  ray;
		logic  fixed;   // expected result typed in the table
		refr_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [14:0] index_from = IDX1, index_to = IDX1;
	logic in_stall, out_valid, total_reflection;
	logic signed [15:0] out_x, out_y, out_z;

	refr_t  refr_q[$];
	int     errors = 0;
	int     cycles = 0;
	row_t   rows[$];

	always #5 clk = ~clk;

	refract_direction_unit_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.index_from(index_from), .index_to(index_to),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.total_reflection(total_reflection)
	);

	// Arithmetic shift right with rounding half up
	function automatic longint rnd_shr(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic longint root_floor(longint v);
		longint rem, root, b;
		rem = v;
		root = 0;
		b = longint'(1) <<< 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >>> 1) + b;
			end else
				root = root >>> 1;
			b = b >>> 2;
		end
		return root;
	endfunction

	// Snell refraction in the block's fixed-point steps
	function automatic refr_t refract(ray_t a);
		refr_t  o;
		longint ratio, d, c1, k, nsq, r, c2, t;
		longint nv[3], iv[3], v[3];
		nv = '{a.nx, a.ny, a.nz};
		iv = '{a.ix, a.iy, a.iz};
		if (a.n2 == 0)
			ratio = 'hFFFFF;
		else begin
			ratio = (longint'(a.n1) <<< 16) / longint'(a.n2);
			if (ratio > 'hFFFFF) ratio = 'hFFFFF;
		end
		d = nv[0] * iv[0] + nv[1] * iv[1] + nv[2] * iv[2];
		c1 = rnd_shr(-d, 14);
		k = (longint'(1) <<< 28) - c1 * c1;
		nsq = (ratio * ratio) >>> 16;
		r = (longint'(1) <<< 44) - nsq * k;
		o = '{x: '0, y: '0, z: '0, tir: 1'b1};
		if (r < 0) return o;
		c2 = root_floor(r);
		t = ratio * c1 - c2 * 256;
		for (int j = 0; j < 3; j++)
			v[j] = clamp16(rnd_shr(ratio * iv[j] * 16384 + t * nv[j], 30));
		o = '{x: v[0][15:0], y: v[1][15:0], z: v[2][15:0], tir: 1'b0};
		return o;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic ray_t mkray(int nx, int ny, int nz, int ix, int iy, int iz,
	                               int n1, int n2);
		ray_t a;
		a = '{nx[15:0], ny[15:0], nz[15:0], ix[15:0], iy[15:0], iz[15:0], n1[14:0], n2[14:0]};
		return a;
	endfunction

	task automatic add_row(ray_t a);
		rows.push_back('{ray: a, fixed: 1'b0, res: '{'0, '0, '0, 1'b0}});
	endtask

	task automatic add_fixed(ray_t a, refr_t e);
		rows.push_back('{ray: a, fixed: 1'b1, res: e});
	endtask

	// Random ray with components within +-1.0 and random signs; some draws use raw noise
	function automatic ray_t rand_ray();
		ray_t a;
		int   sel;
		sel = $urandom_range(0, 9);
		a.nx = 16'($urandom_range(0, 16384)); a.ny = 16'($urandom_range(0, 16384));
		a.nz = 16'($urandom_range(0, 16384));
		a.ix = 16'($urandom_range(0, 16384)); a.iy = 16'($urandom_range(0, 16384));
		a.iz = 16'($urandom_range(0, 16384));
		if ($urandom_range(0, 1)) a.nx = -a.nx;
		if ($urandom_range(0, 1)) a.ny = -a.ny;
		if ($urandom_range(0, 1)) a.nz = -a.nz;
		if ($urandom_range(0, 1)) a.ix = -a.ix;
		if ($urandom_range(0, 1)) a.iy = -a.iy;
		if ($urandom_range(0, 1)) a.iz = -a.iz;
		a.n1 = 15'($urandom_range(8192, 16384));
		a.n2 = 15'($urandom_range(8192, 16384));
		if (sel == 0) begin
			// raw noise over the whole field range
			{a.nx, a.ny, a.nz} = 48'({$urandom, $urandom});
			{a.ix, a.iy, a.iz} = 48'({$urandom, $urandom});
			{a.n1, a.n2} = 30'($urandom);
		end else if (sel == 1) begin
			a.n1 = 15'($urandom_range(4096, 32767));
			a.n2 = 15'($urandom_range(4096, 32767));
		end
		return a;
	endfunction

	// Expected results, checked as they leave the block
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			refr_t e;
			if (refr_q.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				e = refr_q.pop_front();
				if (out_x !== e.x) report("out_x", out_x, e.x);
				if (out_y !== e.y) report("out_y", out_y, e.y);
				if (out_z !== e.z) report("out_z", out_z, e.z);
				if (total_reflection !== e.tir)
					report("total_reflection", total_reflection, e.tir);
			end
		end
	end

	// Receiver stalls in runs, with calm stretches
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 60)) begin
				@(negedge clk);
				out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
			end
		end
	end

	// Present one request and hold it until taken
	task automatic send(ray_t a);
		@(negedge clk);
		in_valid <= 1'b1;
		normal_x <= a.nx; normal_y <= a.ny; normal_z <= a.nz;
		dir_x <= a.ix; dir_y <= a.iy; dir_z <= a.iz;
		index_from <= a.n1; index_to <= a.n2;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_idle();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	initial begin
		int burst;
		ray_t a;
		// Directed rows: straight through, extremes, reflection, index corners
		add_fixed(mkray(0, 0, ONE, 0, 0, -ONE, IDX1, IDX1), '{16'sd0, 16'sd0, -ONE, 1'b0});
		add_fixed(mkray(0, 0, 0, 0, 0, 0, IDX1, IDX1), '{16'sd0, 16'sd0, 16'sd0, 1'b0});
		add_fixed(mkray(0, 0, ONE, ONE, 0, 0, 32767, 4096), '{16'sd0, 16'sd0, 16'sd0, 1'b1});
		add_fixed(mkray(0, 0, 0, 0, 0, 0, 32767, 0), '{16'sd0, 16'sd0, 16'sd0, 1'b1});
		add_row(mkray(0, 0, ONE, 11585, 0, -11585, 12288, 8192));
		add_row(mkray(0, 0, ONE, 11585, 0, -11585, 8192, 12288));
		add_row(mkray(ONE, 0, 0, -11585, 11585, 0, 8192, 10923));
		add_row(mkray(0, ONE, 0, 0, -ONE, 0, 4096, 32767));
		add_row(mkray(0, ONE, 0, 0, -ONE, 0, 32767, 32767));
		add_row(mkray(-32768, -32768, -32768, -32768, -32768, -32768, 4096, 4096));
		add_row(mkray(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		add_row(mkray(32767, -32768, 32767, -32768, 32767, -32768, 0, 32767));
		add_row(mkray(-1, -1, -1, -1, -1, -1, 32767, 4096));
		add_row(mkray(ONE, 0, 0, 0, ONE, 0, 8192, 8192));
		add_row(mkray(ONE, ONE, ONE, ONE, ONE, ONE, 8192, 9000));
		add_row(mkray(0, 0, ONE, 0, 8192, -14189, 12288, 8192));
		add_row(mkray(0, 0, ONE, 0, 16384, -1, 8192, 8192));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			refr_q.push_back(rows[i].fixed ? rows[i].res : refract(rows[i].ray));
			send(rows[i].ray);
		end
		send_idle();

		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
				a = rand_ray();
				refr_q.push_back(refract(a));
				send(a);
			end
			if ($urandom_range(0, 2) != 0) begin
				send_idle();
				repeat ($urandom_range(0, 12)) @(negedge clk);
			end
		end
		send_idle();

		while (refr_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0)
			$display("refract_direction_unit_core test passed");
		else
			$display("refract_direction_unit_core test failed");
		$finish;
	end

	// Watchdog
	initial begin
		wait (cycles >= CYCLE_CAP);
		$display("timeout after %0d cycles", cycles);
		$display("refract_direction_unit_core test failed");
		$finish;
	end

endmodule

`default_nettype wire
